### hw/rtl/bitmap_rank_find_engine_macros.svh
// Assertion macros for the bitmap rank and find engine.
// Used by the top level only; depends on nothing else.
`ifndef BITMAP_RANK_FIND_ENGINE_MACROS_SVH
`define BITMAP_RANK_FIND_ENGINE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BRFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/brfe_pkg.sv
// Shared constants, types and helper functions of the bitmap rank and find engine.
// Used by brfe_digit_unit and bitmap_rank_find_engine; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brfe_pkg;

    localparam int TOTAL_BITS   = 256;
    localparam int DIGIT_W      = 8;
    localparam int OFF_W        = $clog2(DIGIT_W);
    localparam int DIGIT_COUNT  = TOTAL_BITS / DIGIT_W;
    localparam int ADDR_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int SPOS_W       = ADDR_W + OFF_W;
    localparam int CNT_W        = $clog2(TOTAL_BITS + 1);
    localparam int POP_W        = $clog2(DIGIT_W + 1);

    localparam int MODE_W       = 3;
    localparam int POS_W        = 8;
    localparam int RES_W        = 9;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RANK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd4;

    localparam logic [RES_W-1:0] NEG_ONE_9 = 9'h1FF;

    // Per-digit control handed from the sequencer to the digit unit.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [OFF_W-1:0]  offset;
        logic              val;
        logic              first;
        logic              last;
    } op_t;

    // Accumulated query state returned by the digit unit.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              hit;
        logic              found;
        logic [SPOS_W-1:0] found_pos;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    function automatic logic [POP_W-1:0] pop_digit(input logic [DIGIT_W-1:0] d);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            n = n + POP_W'(d[i]);
        end
        return n;
    endfunction

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [OFF_W-1:0] first_one(input logic [DIGIT_W-1:0] d);
        logic [OFF_W-1:0] p;
        p = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            if (d[i])
            begin
                p = OFF_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [RES_W-1:0] sat9(input logic [CNT_W-1:0] v);
        logic [RES_W-1:0] r;
        if (32'(v) > 511)
        begin
            r = 9'h1FF;
        end
        else
        begin
            r = RES_W'(v);
        end
        return r;
    endfunction

    function automatic logic [RES_W-1:0] sat_pos(input logic [SPOS_W-1:0] p);
        logic [RES_W-1:0] r;
        if (32'(p) > 255)
        begin
            r = 9'd255;
        end
        else
        begin
            r = RES_W'(p);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bitmap_rank_find_engine.sv
// Top level of the bitmap rank and find engine: stream ports, bitmap memory and
// scan sequencer. Depends on brfe_pkg, brfe_digit_unit and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_rank_find_engine_macros.svh"

// The engine keeps a 256-bit bitmap, all clear after reset, in a memory of 32
// bytes with one valid bit per byte, so a byte never written reads as zero and
// no clearing pass is needed. Every input item gives exactly one result item.
// The map is walked one byte per cycle through a registered memory read and a
// byte-wide accumulator, so the item time is set by how many bytes a query
// touches: write and read touch one byte, rank touches bytes 0 up to the
// position's byte, find touches bytes from the position's byte up to the first
// matching byte or the last byte, count touches all 32 bytes, and unused
// modes touch none. One item is worked on at a time; the next item is
// taken as soon as the current result sits in the output register, even while
// that result is still waiting for the downstream side.
module bitmap_rank_find_engine
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [7:0] position, [8] bit_value, [15:9] zero
    input  wire logic [brfe_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [2:0] mode
    input  wire logic [brfe_pkg::MODE_W-1:0]        s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] read_bit, [9:1] set_count, [18:10] found_index, [23:19] zero
    output logic [brfe_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    localparam logic [brfe_pkg::ADDR_W-1:0] LAST_ADDR =
        brfe_pkg::ADDR_W'(brfe_pkg::DIGIT_COUNT - 1);

    brfe_pkg::state_t                   state_reg, state_next;

    logic [brfe_pkg::MODE_W-1:0]        mode_reg;
    logic [brfe_pkg::POS_W-1:0]         pos_reg;
    logic                               val_reg;
    logic [brfe_pkg::ADDR_W-1:0]        start_addr_reg, start_addr_next;
    logic [brfe_pkg::ADDR_W-1:0]        end_addr_reg, end_addr_next;
    logic [brfe_pkg::ADDR_W-1:0]        iss_addr_reg, iss_addr_next;
    logic                               iss_on_reg, iss_on_next;
    logic                               proc_on_reg, proc_on_next;
    logic [brfe_pkg::ADDR_W-1:0]        proc_addr_reg;
    logic                               proc_last_reg;

    logic [brfe_pkg::DIGIT_W-1:0]       mem [brfe_pkg::DIGIT_COUNT];
    logic [brfe_pkg::DIGIT_W-1:0]       mem_rd_reg;
    logic                               rd_valid_reg;
    logic [brfe_pkg::DIGIT_COUNT-1:0]   valid_reg;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic                               read_bit_reg;
    logic [brfe_pkg::RES_W-1:0]         set_count_reg;
    logic [brfe_pkg::RES_W-1:0]         found_index_reg;

    logic                               accept;
    logic [brfe_pkg::MODE_W-1:0]        in_mode;
    logic [brfe_pkg::POS_W-1:0]         in_pos;
    logic                               in_pos_ok;
    logic [brfe_pkg::ADDR_W-1:0]        in_digit;
    logic                               scan_needed;
    logic                               iss_last;
    logic                               done_scan;
    logic                               load_out;
    logic [brfe_pkg::OFF_W-1:0]         bit_off;
    logic [brfe_pkg::DIGIT_W-1:0]       cur_digit;
    logic [brfe_pkg::DIGIT_W-1:0]       new_digit;
    logic                               mem_we;

    logic                               res_read_bit;
    logic [brfe_pkg::RES_W-1:0]         res_set_count;
    logic [brfe_pkg::RES_W-1:0]         res_found_index;

    brfe_pkg::op_t                      unit_op;
    brfe_pkg::res_t                     unit_res;

    assign s_tready = (state_reg == brfe_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_mode  = s_tuser;
    assign in_pos   = s_tdata[brfe_pkg::POS_W-1:0];
    assign in_pos_ok = (32'(in_pos) < 32'(brfe_pkg::TOTAL_BITS));
    assign in_digit = brfe_pkg::ADDR_W'(in_pos >> brfe_pkg::OFF_W);

    // Decide which range of bytes the new item walks. Items that need no
    // memory access go straight to the result stage.
    always_comb
    begin
        scan_needed     = 1'b0;
        start_addr_next = start_addr_reg;
        end_addr_next   = end_addr_reg;
        case (in_mode)
            brfe_pkg::MODE_WRITE, brfe_pkg::MODE_READ:
            begin
                scan_needed     = in_pos_ok;
                start_addr_next = in_digit;
                end_addr_next   = in_digit;
            end
            brfe_pkg::MODE_COUNT:
            begin
                scan_needed     = 1'b1;
                start_addr_next = '0;
                end_addr_next   = LAST_ADDR;
            end
            brfe_pkg::MODE_RANK:
            begin
                scan_needed     = in_pos_ok;
                start_addr_next = '0;
                end_addr_next   = in_digit;
            end
            brfe_pkg::MODE_FIND:
            begin
                scan_needed     = in_pos_ok;
                start_addr_next = in_digit;
                end_addr_next   = LAST_ADDR;
            end
            default:
            begin
                scan_needed = 1'b0;
            end
        endcase
    end

    assign iss_last  = (iss_addr_reg == end_addr_reg);
    // A find stops as soon as a match has been recorded.
    assign done_scan = proc_on_reg
                       && (proc_last_reg
                           || (mode_reg == brfe_pkg::MODE_FIND && unit_res.found));
    assign load_out  = (state_reg == brfe_pkg::ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        iss_on_next   = iss_on_reg && !iss_last;
        iss_addr_next = (iss_on_reg && !iss_last) ? iss_addr_reg + 1'b1 : iss_addr_reg;
        proc_on_next  = iss_on_reg;
        case (state_reg)
            brfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (scan_needed)
                    begin
                        iss_on_next   = 1'b1;
                        iss_addr_next = start_addr_next;
                        state_next    = brfe_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = brfe_pkg::ST_FINISH;
                    end
                end
            end
            brfe_pkg::ST_SCAN:
            begin
                if (done_scan)
                begin
                    iss_on_next  = 1'b0;
                    proc_on_next = 1'b0;
                    state_next   = brfe_pkg::ST_FINISH;
                end
            end
            brfe_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = brfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= brfe_pkg::ST_IDLE;
            iss_on_reg   <= 1'b0;
            proc_on_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_on_reg   <= iss_on_next;
            proc_on_reg  <= proc_on_next;
            m_tvalid_reg <= m_tvalid_next;
            if (iss_on_reg)
            begin
                rd_valid_reg <= valid_reg[iss_addr_reg];
            end
            if (mem_we)
            begin
                valid_reg[proc_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg       <= in_mode;
            pos_reg        <= in_pos;
            val_reg        <= s_tdata[brfe_pkg::POS_W];
            start_addr_reg <= start_addr_next;
            end_addr_reg   <= end_addr_next;
        end
        iss_addr_reg  <= iss_addr_next;
        proc_addr_reg <= iss_addr_reg;
        proc_last_reg <= iss_last;
    end

    // Bitmap memory: one registered read port for the scan, one write port for
    // the read-modify-write of a single bit.
    assign bit_off   = pos_reg[brfe_pkg::OFF_W-1:0];
    assign cur_digit = rd_valid_reg ? mem_rd_reg : '0;
    assign new_digit = (cur_digit & ~(brfe_pkg::DIGIT_W'(1) << bit_off))
                       | (brfe_pkg::DIGIT_W'(val_reg) << bit_off);
    assign mem_we    = proc_on_reg && (mode_reg == brfe_pkg::MODE_WRITE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[proc_addr_reg] <= new_digit;
        end
        if (iss_on_reg)
        begin
            mem_rd_reg <= mem[iss_addr_reg];
        end
    end

    assign unit_op.mode   = mode_reg;
    assign unit_op.offset = bit_off;
    assign unit_op.val    = val_reg;
    assign unit_op.first  = (proc_addr_reg == start_addr_reg);
    assign unit_op.last   = proc_last_reg;

    brfe_digit_unit u_digit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (accept),
        .step  (proc_on_reg),
        .digit (cur_digit),
        .addr  (proc_addr_reg),
        .op    (unit_op),
        .res   (unit_res)
    );

    // Result formatting. The unit is cleared on accept, so items that skip the
    // scan see no hit and no match, which gives zero or minus one as required.
    always_comb
    begin
        res_read_bit    = 1'b0;
        res_set_count   = '0;
        res_found_index = '0;
        case (mode_reg)
            brfe_pkg::MODE_READ:
            begin
                res_read_bit = unit_res.hit;
            end
            brfe_pkg::MODE_COUNT:
            begin
                res_set_count = brfe_pkg::sat9(unit_res.count);
            end
            brfe_pkg::MODE_RANK:
            begin
                res_found_index = unit_res.hit ? brfe_pkg::sat9(unit_res.count)
                                               : brfe_pkg::NEG_ONE_9;
            end
            brfe_pkg::MODE_FIND:
            begin
                res_found_index = unit_res.found ? brfe_pkg::sat_pos(unit_res.found_pos)
                                                 : brfe_pkg::NEG_ONE_9;
            end
            default:
            begin
                res_read_bit = 1'b0;
            end
        endcase
    end

    assign m_tvalid_next = load_out || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            read_bit_reg    <= res_read_bit;
            set_count_reg   <= res_set_count;
            found_index_reg <= res_found_index;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, found_index_reg, set_count_reg, read_bit_reg};

    `BRFE_ASSERT_NOW(a_idle_no_scan, clk, rst_n, s_tready, !iss_on_reg && !proc_on_reg,
        "engine accepts an item while a scan is still running")
    `BRFE_ASSERT_NOW(a_rise_from_finish, clk, rst_n, $rose(m_tvalid),
        $past(state_reg == brfe_pkg::ST_FINISH), "result appeared without a finished item")
    `BRFE_ASSERT_NEXT(a_write_marks_valid, clk, rst_n, mem_we,
        valid_reg[$past(proc_addr_reg)], "written byte not marked valid")
    `BRFE_ASSERT_NOW(a_write_single_byte, clk, rst_n, mem_we,
        proc_last_reg && (proc_addr_reg == start_addr_reg), "write touched more than one byte")

endmodule

`default_nettype wire

### hw/rtl/brfe_digit_unit.sv
// Digit-serial accumulator: takes one bitmap digit per step and builds the count,
// read and rank hit and find result. Depends on brfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brfe_digit_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          step,
    input  wire logic [brfe_pkg::DIGIT_W-1:0]  digit,
    input  wire logic [brfe_pkg::ADDR_W-1:0]   addr,
    input  wire brfe_pkg::op_t                 op,
    output brfe_pkg::res_t                     res
);

    logic [brfe_pkg::CNT_W-1:0]   count_reg;
    logic                         hit_reg;
    logic                         found_reg;
    logic [brfe_pkg::SPOS_W-1:0]  found_pos_reg;

    logic [brfe_pkg::DIGIT_W-1:0] below_mask;
    logic [brfe_pkg::DIGIT_W-1:0] pop_src;
    logic [brfe_pkg::DIGIT_W-1:0] match_bits;
    logic                         add_en;

    always_comb
    begin
        below_mask = (brfe_pkg::DIGIT_W'(1) << op.offset) - brfe_pkg::DIGIT_W'(1);
        pop_src    = digit;
        if (op.mode == brfe_pkg::MODE_RANK && op.last)
        begin
            pop_src = digit & below_mask;
        end
        add_en = op.mode inside {brfe_pkg::MODE_COUNT, brfe_pkg::MODE_RANK};
        // A one marks each bit equal to the searched value; the start digit
        // ignores bits below the start position.
        match_bits = op.val ? digit : ~digit;
        if (op.first)
        begin
            match_bits = match_bits & ~below_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            count_reg <= '0;
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (step)
        begin
            if (add_en)
            begin
                count_reg <= count_reg + brfe_pkg::CNT_W'(brfe_pkg::pop_digit(pop_src));
            end
            if ((op.mode inside {brfe_pkg::MODE_READ, brfe_pkg::MODE_RANK}) && op.last)
            begin
                hit_reg <= digit[op.offset];
            end
            if (op.mode == brfe_pkg::MODE_FIND && !found_reg && match_bits != '0)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !found_reg && match_bits != '0)
        begin
            found_pos_reg <= {addr, brfe_pkg::first_one(match_bits)};
        end
    end

    assign res.count     = count_reg;
    assign res.hit       = hit_reg;
    assign res.found     = found_reg;
    assign res.found_pos = found_pos_reg;

endmodule

`default_nettype wire
